// ===== rtl/smt_pkg.sv =====
// Shared constants and types for the sorted multiset table.
`timescale 1ns / 1ps

package smt_pkg;

	localparam int CAPACITY  = 16;
	localparam int VAL_W     = 32;
	localparam int CNT_W     = $clog2(CAPACITY + 1);
	localparam int ENTRIES_W = 5;
	localparam int OUT_DATA_W = ((ENTRIES_W + 7) / 8) * 8;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_REMOVE = 1'b1
	} op_t;

	// Command broadcast to every cell of the row in the cycle an item is taken.
	typedef struct packed {
		logic                    ins_en;
		logic                    rem_en;
		logic signed [VAL_W-1:0] value;
	} cell_cmd_t;

	// What each cell tells the top level and its neighbors.
	typedef struct packed {
		logic                    ge;
		logic                    match;
		logic signed [VAL_W-1:0] value;
	} cell_stat_t;

endpackage

// ===== rtl/smt_cell.sv =====
// One slot of the sorted row: holds a value, compares it to the broadcast key, shifts locally.
`timescale 1ns / 1ps

module smt_cell (
	input  logic                          clk,
	input  smt_pkg::cell_cmd_t            cmd,
	input  logic                          occupied,
	input  logic                          at_count,
	input  logic                          left_ge,
	input  logic signed [smt_pkg::VAL_W-1:0] left_value,
	input  logic signed [smt_pkg::VAL_W-1:0] right_value,
	output smt_pkg::cell_stat_t           stat
);

	logic signed [smt_pkg::VAL_W-1:0] value_q;
	logic signed [smt_pkg::VAL_W-1:0] value_d;
	logic                             ge;

	assign ge = occupied && (value_q >= cmd.value);

	assign stat.ge    = ge;
	assign stat.match = occupied && (value_q == cmd.value);
	assign stat.value = value_q;

	// The row is sorted, so the cells at or past the insert point are exactly
	// those whose own key is not below the new one; the same holds for the
	// first equal key on a remove.
	always_comb begin
		value_d = value_q;
		if (cmd.ins_en) begin
			if (left_ge) begin
				value_d = left_value;
			end else if (ge || at_count) begin
				value_d = cmd.value;
			end
		end else if (cmd.rem_en && ge) begin
			value_d = right_value;
		end
	end

	always_ff @(posedge clk) begin
		value_q <= value_d;
	end

endmodule

// ===== rtl/sorted_multiset_table.sv =====
// Top level of the sorted multiset table: a row of compare-and-shift cells plus the fill count.
`timescale 1ns / 1ps

// The result word is registered and appears on the output in the cycle after its input word is taken.
// One word per cycle unless the output stalls; every cell updates at once from its neighbors.
// A new word is taken while a result waits, provided that result is taken in the same cycle.
// Reset clears the fill count and the output valid; stored values need no clearing.
module sorted_multiset_table (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [smt_pkg::VAL_W-1:0]         s_tdata,  // [31:0] value
	input  logic                              s_tuser,  // [0] op
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [smt_pkg::OUT_DATA_W-1:0]    m_tdata,  // [4:0] entries
	output logic                              m_tuser   // [0] ok
);

	localparam int N = smt_pkg::CAPACITY;

	logic [smt_pkg::CNT_W-1:0]     count_q;
	logic [smt_pkg::CNT_W-1:0]     count_d;
	logic                          out_valid_q;
	logic                          ok_q;
	logic [smt_pkg::ENTRIES_W-1:0] entries_q;

	smt_pkg::cell_cmd_t  cmd;
	smt_pkg::cell_stat_t stat [N];
	logic [N-1:0]        match_vec;
	logic                accept;
	logic                is_insert;
	logic                full;
	logic                found;
	logic                ok_d;
	logic [smt_pkg::CNT_W+smt_pkg::ENTRIES_W-1:0] count_ext;

	assign s_tready  = !out_valid_q || m_tready;
	assign accept    = s_tvalid && s_tready;
	assign is_insert = (smt_pkg::op_t'(s_tuser) == smt_pkg::OP_INSERT);
	assign full      = (count_q == smt_pkg::CNT_W'(N));
	assign found     = |match_vec;

	assign cmd.value  = s_tdata;
	assign cmd.ins_en = accept && is_insert && !full;
	assign cmd.rem_en = accept && !is_insert && found;

	genvar i;
	generate
		for (i = 0; i < N; i++) begin : g_cell
			logic                             left_ge;
			logic signed [smt_pkg::VAL_W-1:0] left_value;
			logic signed [smt_pkg::VAL_W-1:0] right_value;

			if (i == 0) begin : g_first
				assign left_ge    = 1'b0;
				assign left_value = stat[i].value;
			end else begin : g_mid
				assign left_ge    = stat[i-1].ge;
				assign left_value = stat[i-1].value;
			end

			// The last cell only shifts in past the fill count, so its own value will do.
			if (i == N - 1) begin : g_last
				assign right_value = stat[i].value;
			end else begin : g_inner
				assign right_value = stat[i+1].value;
			end

			assign match_vec[i] = stat[i].match;

			smt_cell u_cell (
				.clk         (clk),
				.cmd         (cmd),
				.occupied    (count_q > smt_pkg::CNT_W'(i)),
				.at_count    (count_q == smt_pkg::CNT_W'(i)),
				.left_ge     (left_ge),
				.left_value  (left_value),
				.right_value (right_value),
				.stat        (stat[i])
			);
		end
	endgenerate

	always_comb begin
		count_d = count_q;
		if (cmd.ins_en) begin
			count_d = count_q + smt_pkg::CNT_W'(1);
		end else if (cmd.rem_en) begin
			count_d = count_q - smt_pkg::CNT_W'(1);
		end
	end

	assign ok_d      = cmd.ins_en || cmd.rem_en;
	assign count_ext = {{smt_pkg::ENTRIES_W{1'b0}}, count_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ok_q      <= ok_d;
			entries_q <= count_ext[smt_pkg::ENTRIES_W-1:0];
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = ok_q;
	assign m_tdata  = {{(smt_pkg::OUT_DATA_W - smt_pkg::ENTRIES_W){1'b0}}, entries_q};

endmodule
